// ===== design/cfpe_pkg.sv =====
// Shared types and constants for the Coulomb field point evaluator.
`timescale 1ns / 1ps

package cfpe_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_SCAN   = 2'd1;
  localparam logic [1:0] KIND_RENDER = 2'd2;
  localparam logic [1:0] KIND_RESV   = 2'd3;

  localparam logic [47:0] SAT48      = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] PEAK_RESET = 48'd100;
  localparam logic [38:0] K_HALF_PIX = 39'd3600000000;  // K * 0.1 C * 4 (half-pixel units)
  localparam logic [16:0] Q16_ONE    = 17'd65536;

  // Datapath operations issued by the controller
  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_ADD, OP_READ, OP_DIFF, OP_SQX, OP_SQY,
    OP_SDIV_GO, OP_SDIV_WT, OP_RSQ_GO, OP_RSQ_WT, OP_DEN,
    OP_XDIV_GO, OP_XDIV_WT, OP_YDIV_GO, OP_YDIV_WT, OP_NEXT,
    OP_FIN, OP_DEGEN, OP_NORM, OP_MAGA, OP_MAGB, OP_MSQ_GO, OP_MSQ_WT,
    OP_MAG, OP_DX_GO, OP_DX_WT, OP_DY_GO, OP_DY_WT, OP_RATIO,
    OP_RDIV_GO, OP_RDIV_WT, OP_RT_INIT, OP_RT_MID, OP_RT_MUL, OP_RT_CMP,
    OP_ALPHA, OP_OUT
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic cnt_zero;
    logic last;
    logic scalar;
    logic scan;
    logic zero_field;
    logic norm_ok;
    logic unit_done;
    logic ratio_ge;
    logic rt_done;
    logic mul_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/cfpe_div.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 48-bit divisor.
`timescale 1ns / 1ps

module cfpe_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] nq;
  logic [47:0] rem;
  logic [47:0] dv;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] trial;
  logic        ge;

  assign trial = {rem, nq[63]};
  assign ge    = trial >= {1'b0, dv};
  assign quo   = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      nq  <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      rem <= ge ? 48'(trial - {1'b0, dv}) : trial[47:0];
      nq  <= {nq[62:0], ge};
    end
  end

endmodule

// ===== design/cfpe_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle: 64-bit in, 32-bit out.
`timescale 1ns / 1ps

module cfpe_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val_in,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] val;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [33:0] r4;
  logic [33:0] trial;

  assign r4    = {rem[31:0], val[63:62]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      val  <= val_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val <= {val[61:0], 2'b00};
      if (r4 >= trial) begin
        rem  <= r4 - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= r4;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/cfpe_dpath.sv =====
// Datapath: charge table, per-charge field terms, magnitude, ratio, root search, result.
`timescale 1ns / 1ps

module cfpe_dpath #(
  parameter int MAX_CHARGES   = 64,
  parameter int STEP_PIXELS   = 5,
  parameter int ROOT_DEGREE   = 5,
  parameter int ALPHA_QUANTUM = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfpe_pkg::dp_op_t        cmd,
  output cfpe_pkg::dp_stat_t      stat,
  input  logic [1:0]              in_kind,
  input  logic [10:0]             in_x,
  input  logic [10:0]             in_y,
  input  logic signed [7:0]       in_q,
  input  logic                    mode,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_alpha,
  output logic [11:0]             out_dx,
  output logic [11:0]             out_dy,
  output logic                    out_deg
);

  import cfpe_pkg::*;

  localparam int AW          = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
  localparam int CW          = $clog2(MAX_CHARGES + 1);
  localparam int KW          = $clog2(ROOT_DEGREE + 1);
  localparam int DIR_SCALE   = STEP_PIXELS * 256;
  localparam int ALPHA_STEPS = 255 / ALPHA_QUANTUM;

  localparam logic signed [50:0] SAT_POS = 51'sd281474976710655;
  localparam logic signed [50:0] SAT_NEG = -51'sd281474976710655;

  // charge table
  logic [11:0]       mem_cx [MAX_CHARGES];
  logic [11:0]       mem_cy [MAX_CHARGES];
  logic signed [7:0] mem_q  [MAX_CHARGES];
  logic [11:0]       rd_cx, rd_cy;
  logic signed [7:0] rd_q;

  logic [CW-1:0]     count, idx;
  logic [47:0]       peak;
  logic              full;

  logic [10:0]       px, py;
  logic signed [7:0] qin, q_sat;
  logic              scalar_r, scan_r;

  logic signed [12:0] dx, dy;
  logic [11:0]        adx, ady;
  logic               qneg, dxneg, dyneg;
  logic [6:0]         aq;
  logic [38:0]        kq;
  logic [62:0]        sq;
  logic [25:0]        d2;
  logic [21:0]        sroot;
  logic [47:0]        den;
  logic [47:0]        s_sum;
  logic [48:0]        s_add;
  logic signed [48:0] ex, ey;
  logic               exneg, eyneg;
  logic [47:0]        mx, my;
  logic [4:0]         sh;
  logic [31:0]        m;
  logic [48:0]        m_sh;
  logic [47:0]        strength;
  logic [16:0]        ratio;
  logic [16:0]        lo, hi, mid, p;
  logic [33:0]        pm;
  logic [KW-1:0]      k;
  logic [24:0]        a0, a1;
  logic [15:0]        a1q;
  logic [7:0]         res_alpha;
  logic [11:0]        res_dx, res_dy;
  logic               res_deg;

  logic [11:0]        ad_sel;
  logic [50:0]        kq_ad;
  logic [30:0]        mag_sel;
  logic [61:0]        sqv;
  logic [30:0]        dir_sel;
  logic [63:0]        dir_num;

  logic               div_start, div_done;
  logic [63:0]        div_num, div_quo;
  logic [47:0]        div_den;
  logic               sq_start, sq_done;
  logic [63:0]        sq_in;
  logic [31:0]        sq_root;

  function automatic logic signed [48:0] acc_clamp(input logic signed [48:0] acc,
                                                   input logic [47:0] mag,
                                                   input logic neg);
    logic signed [50:0] t;
    logic signed [50:0] s;
    t = neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
    s = $signed({{2{acc[48]}}, acc}) + t;
    if (s > SAT_POS) return SAT_POS[48:0];
    if (s < SAT_NEG) return SAT_NEG[48:0];
    return s[48:0];
  endfunction

  assign full  = count == CW'(MAX_CHARGES);
  assign q_sat = (qin > 8'sd100) ? 8'sd100 : ((qin < -8'sd100) ? -8'sd100 : qin);
  assign adx   = dx[12] ? 12'(-dx) : dx[11:0];
  assign ady   = dy[12] ? 12'(-dy) : dy[11:0];

  assign ad_sel  = (cmd == OP_YDIV_GO) ? ady : adx;
  assign kq_ad   = 51'(kq) * 51'(ad_sel);
  assign mag_sel = (cmd == OP_MAGB) ? my[30:0] : mx[30:0];
  assign sqv     = 62'(mag_sel) * 62'(mag_sel);
  assign dir_sel = (cmd == OP_DY_GO) ? my[30:0] : mx[30:0];
  assign dir_num = 64'(dir_sel) * 64'(DIR_SCALE);
  assign s_add   = {1'b0, s_sum} + {1'b0, div_quo[47:0]};
  assign m_sh    = {17'b0, m} << sh;
  assign pm      = 34'(p) * 34'(mid);
  assign a0      = 25'(lo) * 25'd255;
  assign a1      = 25'(lo) * 25'(ALPHA_STEPS);
  assign a1q     = 16'(a1[24:16]) * 16'(ALPHA_QUANTUM);

  // unit operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    sq_in     = '0;
    case (cmd)
      OP_SDIV_GO: begin
        div_start = 1'b1;
        div_num   = 64'(kq);
        div_den   = 48'(d2);
      end
      OP_XDIV_GO, OP_YDIV_GO: begin
        div_start = 1'b1;
        div_num   = {5'b0, kq_ad, 8'b0};
        div_den   = den;
      end
      OP_DX_GO, OP_DY_GO: begin
        div_start = 1'b1;
        div_num   = dir_num;
        div_den   = 48'(m);
      end
      OP_RDIV_GO: begin
        div_start = 1'b1;
        div_num   = {strength, 16'b0};
        div_den   = peak;
      end
      OP_RSQ_GO: begin
        sq_start = 1'b1;
        sq_in    = {22'b0, d2, 16'b0};
      end
      OP_MSQ_GO: begin
        sq_start = 1'b1;
        sq_in    = {1'b0, sq};
      end
      default: begin
      end
    endcase
  end

  cfpe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  cfpe_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .val_in (sq_in),
    .done   (sq_done),
    .root   (sq_root)
  );

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd == OP_ADD && !full) begin
      mem_cx[count[AW-1:0]] <= {px, 1'b1};
      mem_cy[count[AW-1:0]] <= {py, 1'b1};
      mem_q[count[AW-1:0]]  <= q_sat;
    end
    if (cmd == OP_READ) begin
      rd_cx <= mem_cx[idx[AW-1:0]];
      rd_cy <= mem_cy[idx[AW-1:0]];
      rd_q  <= mem_q[idx[AW-1:0]];
    end
  end

  // control state: fill count, running peak, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      peak      <= PEAK_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cmd == OP_ADD && !full) count <= count + CW'(1);
      if (cmd == OP_FIN && scan_r && s_sum > peak) peak <= s_sum;
      if (cmd == OP_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd)
      OP_LOAD: begin
        px       <= in_x;
        py       <= in_y;
        qin      <= in_q;
        scan_r   <= in_kind == KIND_SCAN;
        scalar_r <= (in_kind == KIND_SCAN) || mode;
        idx      <= '0;
        s_sum    <= '0;
        ex       <= '0;
        ey       <= '0;
        res_dx   <= '0;
        res_dy   <= '0;
        res_deg  <= 1'b0;
      end
      OP_DIFF: begin
        dx   <= $signed({1'b0, px, 1'b0}) - $signed({1'b0, rd_cx});
        dy   <= $signed({1'b0, py, 1'b0}) - $signed({1'b0, rd_cy});
        aq   <= rd_q[7] ? 7'(-rd_q) : rd_q[6:0];
        qneg <= rd_q[7];
      end
      OP_SQX: begin
        sq    <= 63'(adx) * 63'(adx);
        kq    <= K_HALF_PIX * 39'(aq);
        dxneg <= dx[12];
        dyneg <= dy[12];
      end
      OP_SQY:     d2 <= 26'(sq[23:0]) + 26'(ady) * 26'(ady);
      OP_SDIV_WT: if (div_done) s_sum <= s_add[48] ? SAT48 : s_add[47:0];
      OP_RSQ_WT:  if (sq_done) sroot <= sq_root[21:0];
      OP_DEN:     den <= 48'(d2) * 48'(sroot);
      OP_XDIV_WT: if (div_done) ex <= acc_clamp(ex, div_quo[47:0], qneg ^ dxneg);
      OP_YDIV_WT: if (div_done) ey <= acc_clamp(ey, div_quo[47:0], qneg ^ dyneg);
      OP_NEXT:    idx <= idx + CW'(1);
      OP_FIN: begin
        strength <= s_sum;
        mx       <= 48'(ex[48] ? -ex : ex);
        my       <= 48'(ey[48] ? -ey : ey);
        exneg    <= ex[48];
        eyneg    <= ey[48];
        sh       <= '0;
      end
      OP_DEGEN: begin
        res_deg   <= 1'b1;
        res_alpha <= '0;
      end
      OP_NORM: begin
        if (!stat.norm_ok) begin
          mx <= mx >> 1;
          my <= my >> 1;
          sh <= sh + 5'd1;
        end
      end
      OP_MAGA:   sq <= {1'b0, sqv};
      OP_MAGB:   sq <= sq + {1'b0, sqv};
      OP_MSQ_WT: if (sq_done) m <= sq_root;
      OP_MAG:    strength <= (48'(m) >= (SAT48 >> sh)) ? SAT48 : m_sh[47:0];
      OP_DX_WT:  if (div_done) res_dx <= exneg ? 12'(-div_quo[11:0]) : div_quo[11:0];
      OP_DY_WT:  if (div_done) res_dy <= eyneg ? 12'(-div_quo[11:0]) : div_quo[11:0];
      OP_RATIO:  if (strength >= peak) ratio <= Q16_ONE;
      OP_RDIV_WT: if (div_done) ratio <= div_quo[16:0];
      OP_RT_INIT: begin
        lo <= '0;
        hi <= Q16_ONE;
      end
      OP_RT_MID: begin
        mid <= lo + 17'((18'(hi) - 18'(lo) + 18'd1) >> 1);
        p   <= Q16_ONE;
        k   <= '0;
      end
      OP_RT_MUL: begin
        p <= pm[32:16];
        k <= k + KW'(1);
      end
      OP_RT_CMP: begin
        if (p <= ratio) lo <= mid;
        else hi <= mid - 17'd1;
      end
      OP_ALPHA: res_alpha <= scalar_r ? a1q[7:0] : a0[23:16];
      OP_OUT: begin
        if (!out_valid || out_ready) begin
          out_alpha <= res_alpha;
          out_dx    <= res_dx;
          out_dy    <= res_dy;
          out_deg   <= res_deg;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.cnt_zero   = count == '0;
    stat.last       = (idx + CW'(1)) == count;
    stat.scalar     = scalar_r;
    stat.scan       = scan_r;
    stat.zero_field = (ex == '0) && (ey == '0);
    stat.norm_ok    = ~|mx[47:31] && ~|my[47:31];
    stat.unit_done  = div_done || sq_done;
    stat.ratio_ge   = strength >= peak;
    stat.rt_done    = lo >= hi;
    stat.mul_last   = k == KW'(ROOT_DEGREE - 1);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== design/cfpe_ctrl.sv =====
// Controller: sequences the datapath through charge walk, magnitude, ratio and root search.
`timescale 1ns / 1ps

module cfpe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  output logic                 in_ready,
  output cfpe_pkg::dp_op_t     cmd,
  input  cfpe_pkg::dp_stat_t   stat
);

  import cfpe_pkg::*;

  typedef enum logic [36:0] {
    S_IDLE    = 37'd1 << 0,  S_ADD     = 37'd1 << 1,  S_READ    = 37'd1 << 2,
    S_DIFF    = 37'd1 << 3,  S_SQX     = 37'd1 << 4,  S_SQY     = 37'd1 << 5,
    S_SDIV_GO = 37'd1 << 6,  S_SDIV_WT = 37'd1 << 7,  S_RSQ_GO  = 37'd1 << 8,
    S_RSQ_WT  = 37'd1 << 9,  S_DEN     = 37'd1 << 10, S_XDIV_GO = 37'd1 << 11,
    S_XDIV_WT = 37'd1 << 12, S_YDIV_GO = 37'd1 << 13, S_YDIV_WT = 37'd1 << 14,
    S_NEXT    = 37'd1 << 15, S_FIN     = 37'd1 << 16, S_DEGEN   = 37'd1 << 17,
    S_NORM    = 37'd1 << 18, S_MAGA    = 37'd1 << 19, S_MAGB    = 37'd1 << 20,
    S_MSQ_GO  = 37'd1 << 21, S_MSQ_WT  = 37'd1 << 22, S_MAG     = 37'd1 << 23,
    S_DX_GO   = 37'd1 << 24, S_DX_WT   = 37'd1 << 25, S_DY_GO   = 37'd1 << 26,
    S_DY_WT   = 37'd1 << 27, S_RATIO   = 37'd1 << 28, S_RDIV_GO = 37'd1 << 29,
    S_RDIV_WT = 37'd1 << 30, S_RT_INIT = 37'd1 << 31, S_RT_MID  = 37'd1 << 32,
    S_RT_MUL  = 37'd1 << 33, S_RT_CMP  = 37'd1 << 34, S_ALPHA   = 37'd1 << 35,
    S_OUT     = 37'd1 << 36
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd = OP_LOAD;
          case (in_kind)
            KIND_ADD:    state_next = S_ADD;
            KIND_SCAN,
            KIND_RENDER: state_next = stat.cnt_zero ? S_FIN : S_READ;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        cmd = OP_ADD;
        state_next = S_IDLE;
      end
      S_READ: begin cmd = OP_READ; state_next = S_DIFF; end
      S_DIFF: begin cmd = OP_DIFF; state_next = S_SQX; end
      S_SQX:  begin cmd = OP_SQX;  state_next = S_SQY; end
      S_SQY: begin
        cmd = OP_SQY;
        state_next = stat.scalar ? S_SDIV_GO : S_RSQ_GO;
      end
      S_SDIV_GO: begin cmd = OP_SDIV_GO; state_next = S_SDIV_WT; end
      S_SDIV_WT: begin
        cmd = OP_SDIV_WT;
        if (stat.unit_done) state_next = S_NEXT;
      end
      S_RSQ_GO: begin cmd = OP_RSQ_GO; state_next = S_RSQ_WT; end
      S_RSQ_WT: begin
        cmd = OP_RSQ_WT;
        if (stat.unit_done) state_next = S_DEN;
      end
      S_DEN:     begin cmd = OP_DEN; state_next = S_XDIV_GO; end
      S_XDIV_GO: begin cmd = OP_XDIV_GO; state_next = S_XDIV_WT; end
      S_XDIV_WT: begin
        cmd = OP_XDIV_WT;
        if (stat.unit_done) state_next = S_YDIV_GO;
      end
      S_YDIV_GO: begin cmd = OP_YDIV_GO; state_next = S_YDIV_WT; end
      S_YDIV_WT: begin
        cmd = OP_YDIV_WT;
        if (stat.unit_done) state_next = S_NEXT;
      end
      S_NEXT: begin
        cmd = OP_NEXT;
        state_next = stat.last ? S_FIN : S_READ;
      end
      S_FIN: begin
        cmd = OP_FIN;
        if (stat.scan) state_next = S_IDLE;
        else if (stat.scalar) state_next = S_RATIO;
        else if (stat.zero_field) state_next = S_DEGEN;
        else state_next = S_NORM;
      end
      S_DEGEN: begin cmd = OP_DEGEN; state_next = S_OUT; end
      S_NORM: begin
        cmd = OP_NORM;
        if (stat.norm_ok) state_next = S_MAGA;
      end
      S_MAGA:   begin cmd = OP_MAGA; state_next = S_MAGB; end
      S_MAGB:   begin cmd = OP_MAGB; state_next = S_MSQ_GO; end
      S_MSQ_GO: begin cmd = OP_MSQ_GO; state_next = S_MSQ_WT; end
      S_MSQ_WT: begin
        cmd = OP_MSQ_WT;
        if (stat.unit_done) state_next = S_MAG;
      end
      S_MAG:   begin cmd = OP_MAG; state_next = S_DX_GO; end
      S_DX_GO: begin cmd = OP_DX_GO; state_next = S_DX_WT; end
      S_DX_WT: begin
        cmd = OP_DX_WT;
        if (stat.unit_done) state_next = S_DY_GO;
      end
      S_DY_GO: begin cmd = OP_DY_GO; state_next = S_DY_WT; end
      S_DY_WT: begin
        cmd = OP_DY_WT;
        if (stat.unit_done) state_next = S_RATIO;
      end
      S_RATIO: begin
        cmd = OP_RATIO;
        state_next = stat.ratio_ge ? S_RT_INIT : S_RDIV_GO;
      end
      S_RDIV_GO: begin cmd = OP_RDIV_GO; state_next = S_RDIV_WT; end
      S_RDIV_WT: begin
        cmd = OP_RDIV_WT;
        if (stat.unit_done) state_next = S_RT_INIT;
      end
      S_RT_INIT: begin cmd = OP_RT_INIT; state_next = S_RT_MID; end
      S_RT_MID: begin
        cmd = OP_RT_MID;
        state_next = stat.rt_done ? S_ALPHA : S_RT_MUL;
      end
      S_RT_MUL: begin
        cmd = OP_RT_MUL;
        if (stat.mul_last) state_next = S_RT_CMP;
      end
      S_RT_CMP: begin cmd = OP_RT_CMP; state_next = S_RT_MID; end
      S_ALPHA:  begin cmd = OP_ALPHA; state_next = S_OUT; end
      S_OUT: begin
        cmd = OP_OUT;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/coulomb_field_point_evaluator.sv =====
// Top level of the Coulomb field point evaluator: ports, mode register, control and datapath.
`timescale 1ns / 1ps

//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------------------------
//  s (in)    | s_tvalid / s_tready | tuser: kind; tdata: pos_x, pos_y, charge_tenths
//  m (out)   | m_tvalid / m_tready | tuser: degenerate; tdata: alpha, dir_x, dir_y
//  cfg       | cfg_wr_en           | cfg_wr_data: display_mode
//
// One request at a time; s_tready is high only while the controller is idle.
// Add: one table write. Scan: one division per stored charge by the
// bit-serial divider. Render, scalar mode: the same per-charge division,
// then the ratio division and the fifth-root search. Render, vector mode:
// one square root and two divisions per charge, then normalize, magnitude
// root, two direction divisions, ratio division and root search (17 probes
// of ROOT_DEGREE multiplies each).
// Reset (rst, synchronous): empty table, peak 100, mode 0, output empty.
// The finished result sits in the output register; a new request is taken
// while it waits, and the next result stalls only if it is still unclaimed.

module coulomb_field_point_evaluator #(
  parameter int MAX_CHARGES   = 64,
  parameter int STEP_PIXELS   = 5,
  parameter int ROOT_DEGREE   = 5,
  parameter int ALPHA_QUANTUM = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [10:0] pos_x, [21:11] pos_y, [29:22] charge_tenths
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] alpha, [19:8] dir_x, [31:20] dir_y
  output logic [0:0]  m_tuser,   // [0] degenerate
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  import cfpe_pkg::*;

  logic        display_mode;
  dp_op_t      cmd;
  dp_stat_t    stat;
  logic [7:0]  out_alpha;
  logic [11:0] out_dx, out_dy;
  logic        out_deg;

  // mode must be changed only while idle (the block does not enforce it); the datapath samples it at request load
  always_ff @(posedge clk) begin
    if (rst) display_mode <= 1'b0;
    else if (cfg_wr_en) display_mode <= cfg_wr_data;
  end

  cfpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  cfpe_dpath #(
    .MAX_CHARGES   (MAX_CHARGES),
    .STEP_PIXELS   (STEP_PIXELS),
    .ROOT_DEGREE   (ROOT_DEGREE),
    .ALPHA_QUANTUM (ALPHA_QUANTUM)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (s_tuser),
    .in_x      (s_tdata[10:0]),
    .in_y      (s_tdata[21:11]),
    .in_q      ($signed(s_tdata[29:22])),
    .mode      (display_mode),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_alpha (out_alpha),
    .out_dx    (out_dx),
    .out_dy    (out_dy),
    .out_deg   (out_deg)
  );

  assign m_tdata = {out_dy, out_dx, out_alpha};
  assign m_tuser = out_deg;

  // a real request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser != KIND_RESV) |=> !s_tready)
    else $error("request accepted but controller stayed idle");

  // a zero field reports no alpha and no direction
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
    else $error("degenerate result carries nonzero payload");

  // results are produced only by a request in flight
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while controller was idle");

endmodule
